@@ sv/bsoc_pkg.sv @@
package bsoc_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int NORM_FRAC       = 28;
    localparam int QUOT_W          = 29;
    localparam int NRM_W           = 30;
    localparam int SQ_STEPS        = 32;
    localparam int DIV_STEPS       = 29;
    localparam int CNT_W           = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQX,
        ST_SQY,
        ST_SQSUM,
        ST_SQRT,
        ST_DIVINIT,
        ST_DIV,
        ST_MULX,
        ST_MULY,
        ST_SUMY,
        ST_D3INIT,
        ST_D3,
        ST_FINISH,
        ST_EMIT_HELD,
        ST_EMIT_NEW
    } state_t;

    typedef struct packed {
        logic accept;
        logic norm;
        logic sq_x;
        logic sq_y;
        logic sq_sum;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic mul_x;
        logic mul_y;
        logic sum_y;
        logic d3_init;
        logic d3_step;
        logic store_held;
        logic load_held;
        logic load_new;
        logic path_last;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic norm_done;
    } status_t;

endpackage

@@ sv/bsoc_ctrl.sv @@
module bsoc_ctrl #(
    parameter int COORD_WIDTH = bsoc_pkg::COORD_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              path_end,
    output logic              out_valid,
    input  logic              out_ready,
    input  bsoc_pkg::status_t status,
    output bsoc_pkg::cmd_t    cmd
);

    localparam int D3_STEPS = (COORD_WIDTH + 4 + 3) / 4;

    bsoc_pkg::state_t state_reg, state_next;
    logic [bsoc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] points_seen_reg, points_seen_next;
    logic held_pending_reg, held_pending_next;
    logic emit_reg, emit_next;
    logic end_reg, end_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bsoc_pkg::ST_IDLE;
            cnt_reg          <= '0;
            points_seen_reg  <= '0;
            held_pending_reg <= 1'b0;
            emit_reg         <= 1'b0;
            end_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            points_seen_reg  <= points_seen_next;
            held_pending_reg <= held_pending_next;
            emit_reg         <= emit_next;
            end_reg          <= end_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        points_seen_next  = points_seen_reg;
        held_pending_next = held_pending_reg;
        emit_next         = emit_reg;
        end_next          = end_reg;
        in_ready          = 1'b0;
        cmd               = '0;
        cmd.path_last     = end_reg;
        case (state_reg)
            bsoc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    emit_next  = (points_seen_reg == 2'd3);
                    end_next   = path_end;
                    if (path_end)
                        points_seen_next = 2'd0;
                    else if (points_seen_reg != 2'd3)
                        points_seen_next = points_seen_reg + 2'd1;
                    if (points_seen_reg == 2'd3 || (points_seen_reg == 2'd2 && !path_end))
                        state_next = bsoc_pkg::ST_NORM;
                end
            end
            bsoc_pkg::ST_NORM:
            begin
                if (status.zero)
                    state_next = bsoc_pkg::ST_MULX;
                else if (status.norm_done)
                    state_next = bsoc_pkg::ST_SQX;
                else
                    cmd.norm = 1'b1;
            end
            bsoc_pkg::ST_SQX:
            begin
                cmd.sq_x   = 1'b1;
                state_next = bsoc_pkg::ST_SQY;
            end
            bsoc_pkg::ST_SQY:
            begin
                cmd.sq_y   = 1'b1;
                state_next = bsoc_pkg::ST_SQSUM;
            end
            bsoc_pkg::ST_SQSUM:
            begin
                cmd.sq_sum = 1'b1;
                cnt_next   = bsoc_pkg::CNT_W'(bsoc_pkg::SQ_STEPS - 1);
                state_next = bsoc_pkg::ST_SQRT;
            end
            bsoc_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = bsoc_pkg::ST_DIVINIT;
            end
            bsoc_pkg::ST_DIVINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = bsoc_pkg::CNT_W'(bsoc_pkg::DIV_STEPS - 1);
                state_next   = bsoc_pkg::ST_DIV;
            end
            bsoc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = bsoc_pkg::ST_MULX;
            end
            bsoc_pkg::ST_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = bsoc_pkg::ST_MULY;
            end
            bsoc_pkg::ST_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = bsoc_pkg::ST_SUMY;
            end
            bsoc_pkg::ST_SUMY:
            begin
                cmd.sum_y  = 1'b1;
                state_next = bsoc_pkg::ST_D3INIT;
            end
            bsoc_pkg::ST_D3INIT:
            begin
                cmd.d3_init = 1'b1;
                cnt_next    = bsoc_pkg::CNT_W'(D3_STEPS - 1);
                state_next  = bsoc_pkg::ST_D3;
            end
            bsoc_pkg::ST_D3:
            begin
                cmd.d3_step = 1'b1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = bsoc_pkg::ST_FINISH;
            end
            bsoc_pkg::ST_FINISH:
            begin
                if (!emit_reg)
                begin
                    cmd.store_held    = 1'b1;
                    held_pending_next = 1'b1;
                    state_next        = bsoc_pkg::ST_IDLE;
                end
                else if (held_pending_reg)
                    state_next = bsoc_pkg::ST_EMIT_HELD;
                else
                    state_next = bsoc_pkg::ST_EMIT_NEW;
            end
            bsoc_pkg::ST_EMIT_HELD:
            begin
                if (out_free)
                begin
                    cmd.load_held     = 1'b1;
                    held_pending_next = 1'b0;
                    state_next        = bsoc_pkg::ST_EMIT_NEW;
                end
            end
            bsoc_pkg::ST_EMIT_NEW:
            begin
                if (out_free)
                begin
                    cmd.load_new = 1'b1;
                    state_next   = bsoc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsoc_pkg::ST_IDLE;
            end
        endcase
        if (cmd.load_held || cmd.load_new)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    a_pending_full: assert property (@(posedge clk) disable iff (!rst_n)
        (held_pending_reg && state_reg == bsoc_pkg::ST_IDLE) |-> (points_seen_reg == 2'd3))
        else $error("held result pending without a full window");

    a_emit_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsoc_pkg::ST_EMIT_HELD) |-> held_pending_reg)
        else $error("emitting a held result that is not pending");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_held || cmd.load_new) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while stalled");

    a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && path_end) |=> (points_seen_reg == 2'd0))
        else $error("path end did not clear the window count");

endmodule

@@ sv/bsoc_dpath.sv @@
module bsoc_dpath #(
    parameter int COORD_WIDTH = bsoc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic signed [COORD_WIDTH-1:0] cfg_wr_data,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic                          path_end,
    input  bsoc_pkg::cmd_t                cmd,
    output bsoc_pkg::status_t             status,
    output logic signed [COORD_WIDTH-1:0] curve_x,
    output logic signed [COORD_WIDTH-1:0] curve_y,
    output logic                          zero_tangent,
    output logic                          run_last,
    output logic                          path_last
);

    localparam int W    = COORD_WIDTH;
    localparam int PW   = W + 3;
    localparam int DW   = W + 1;
    localparam int MW   = (W + 1 > 32) ? W + 1 : 32;
    localparam int NW   = bsoc_pkg::NRM_W;
    localparam int QW   = bsoc_pkg::QUOT_W;
    localparam int PRW  = W + 3 + NW;
    localparam int UW   = W + 4;
    localparam int VPW  = ((W + 4 + 3) / 4) * 4;
    localparam int NF   = bsoc_pkg::NORM_FRAC;
    localparam logic [VPW-1:0] D3_BIAS = VPW'(3) << (W + 1);
    localparam logic signed [W+2:0] RES_BIAS = (W + 3)'(1) << (W + 1);
    localparam logic signed [W+2:0] SAT_HI = $signed({4'b0000, {(W - 1){1'b1}}});
    localparam logic signed [W+2:0] SAT_LO = $signed({4'b1111, {(W - 1){1'b0}}});

    logic signed [W-1:0]   older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic signed [W+2:0]   d6_reg;
    logic signed [PW-1:0]  px_reg, py_reg;
    logic [MW-1:0]         sx_reg, sy_reg;
    logic                  dxneg_reg, dyneg_reg, zero_reg;
    logic [61:0]           sqp_reg;
    logic [63:0]           rem_reg, root_reg, bit_reg;
    logic [31:0]           drem_x_reg, drem_y_reg;
    logic [QW-1:0]         dq_x_reg, dq_y_reg;
    logic signed [PRW-1:0] mprod_reg;
    logic signed [UW-1:0]  ux_reg, uy_reg;
    logic [VPW-1:0]        v_x_reg, v_y_reg, q_x_reg, q_y_reg;
    logic [1:0]            r_x_reg, r_y_reg;
    logic signed [W-1:0]   held_x_reg, held_y_reg;
    logic                  held_z_reg;
    logic signed [W-1:0]   curve_x_reg, curve_y_reg;
    logic                  zero_tangent_reg, run_last_reg, path_last_reg;

    logic signed [PW-1:0]  sum_px, sum_py;
    logic signed [DW-1:0]  dx, dy;
    logic [DW-1:0]         mag_dx, mag_dy;
    logic [MW-1:0]         m;
    logic [30:0]           sx_n, sy_n, sq_op;
    logic [63:0]           sq_t;
    logic [31:0]           len;
    logic [59:0]           num_x, num_y;
    logic signed [NW-1:0]  nx, ny;
    logic [5:0]            d3_x, d3_y;
    logic signed [W+2:0]   rx, ry;
    logic signed [W-1:0]   sat_x, sat_y;

    function automatic logic [32+QW-1:0] div_step(input logic [31:0] r,
                                                   input logic [QW-1:0] q,
                                                   input logic [31:0] l);
        logic [32:0] t;
        logic        ge;
        t  = {r, q[QW-1]};
        ge = (t >= {1'b0, l});
        return {(ge ? 32'(t - {1'b0, l}) : t[31:0]), q[QW-2:0], ge};
    endfunction

    function automatic logic [5:0] div3_nibble(input logic [1:0] r, input logic [3:0] nib);
        logic [2:0] t;
        logic [1:0] rr;
        logic [3:0] q;
        rr = r;
        q  = '0;
        for (int i = 3; i >= 0; i--)
        begin
            t = {rr, nib[i]};
            if (t >= 3'd3)
            begin
                rr   = 2'(t - 3'd3);
                q[i] = 1'b1;
            end
            else
                rr = t[1:0];
        end
        return {rr, q};
    endfunction

    function automatic logic signed [W-1:0] saturate(input logic signed [W+2:0] v);
        if (v > SAT_HI)
            return SAT_HI[W-1:0];
        else if (v < SAT_LO)
            return SAT_LO[W-1:0];
        else
            return v[W-1:0];
    endfunction

    assign sum_px = PW'(older_x_reg) + (PW'(newer_x_reg) <<< 2) + PW'(point_x);
    assign sum_py = PW'(older_y_reg) + (PW'(newer_y_reg) <<< 2) + PW'(point_y);
    assign dx     = DW'(point_x) - DW'(older_x_reg);
    assign dy     = DW'(point_y) - DW'(older_y_reg);
    assign mag_dx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign mag_dy = dy[DW-1] ? DW'(-dy) : DW'(dy);

    assign m                = (sx_reg > sy_reg) ? sx_reg : sy_reg;
    assign status.norm_done = ((m >> 30) == MW'(1));
    assign status.zero      = zero_reg;

    assign sx_n  = sx_reg[30:0];
    assign sy_n  = sy_reg[30:0];
    assign sq_op = cmd.sq_x ? sx_n : sy_n;
    assign sq_t  = root_reg + bit_reg;
    assign len   = root_reg[31:0];
    assign num_x = {sx_n, {NF{1'b0}}} + 60'(len >> 1);
    assign num_y = {sy_n, {NF{1'b0}}} + 60'(len >> 1);

    assign nx = zero_reg ? '0 : (dyneg_reg ? NW'(dq_y_reg) : -NW'(dq_y_reg));
    assign ny = zero_reg ? '0 : (dxneg_reg ? -NW'(dq_x_reg) : NW'(dq_x_reg));

    assign d3_x = div3_nibble(r_x_reg, v_x_reg[VPW-1 -: 4]);
    assign d3_y = div3_nibble(r_y_reg, v_y_reg[VPW-1 -: 4]);

    assign rx    = $signed({1'b0, q_x_reg[W+1:0]}) - RES_BIAS;
    assign ry    = $signed({1'b0, q_y_reg[W+1:0]}) - RES_BIAS;
    assign sat_x = saturate(rx);
    assign sat_y = saturate(ry);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d6_reg <= '0;
        else if (cfg_wr_en)
            d6_reg <= ((W + 3)'(cfg_wr_data) <<< 2) + ((W + 3)'(cfg_wr_data) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg    <= sum_px;
            py_reg    <= sum_py;
            sx_reg    <= MW'(mag_dx);
            sy_reg    <= MW'(mag_dy);
            dxneg_reg <= dx[DW-1];
            dyneg_reg <= dy[DW-1];
            zero_reg  <= (dx == '0) && (dy == '0);
            if (path_end)
            begin
                older_x_reg <= '0;
                older_y_reg <= '0;
                newer_x_reg <= '0;
                newer_y_reg <= '0;
            end
            else
            begin
                older_x_reg <= newer_x_reg;
                older_y_reg <= newer_y_reg;
                newer_x_reg <= point_x;
                newer_y_reg <= point_y;
            end
        end

        if (cmd.norm)
        begin
            if ((m >> 31) != '0)
            begin
                sx_reg <= sx_reg >> 1;
                sy_reg <= sy_reg >> 1;
            end
            else if ((m >> 22) == '0)
            begin
                sx_reg <= sx_reg << 8;
                sy_reg <= sy_reg << 8;
            end
            else
            begin
                sx_reg <= sx_reg << 1;
                sy_reg <= sy_reg << 1;
            end
        end

        if (cmd.sq_x || cmd.sq_y)
            sqp_reg <= sq_op * sq_op;
        if (cmd.sq_y)
            rem_reg <= 64'(sqp_reg);
        if (cmd.sq_sum)
        begin
            rem_reg  <= rem_reg + 64'(sqp_reg);
            root_reg <= '0;
            bit_reg  <= 64'(1) << 62;
        end
        if (cmd.sqrt_step)
        begin
            if (rem_reg >= sq_t)
            begin
                rem_reg  <= rem_reg - sq_t;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.div_init)
        begin
            drem_x_reg <= 32'(num_x[59:QW]);
            dq_x_reg   <= num_x[QW-1:0];
            drem_y_reg <= 32'(num_y[59:QW]);
            dq_y_reg   <= num_y[QW-1:0];
        end
        if (cmd.div_step)
        begin
            {drem_x_reg, dq_x_reg} <= div_step(drem_x_reg, dq_x_reg, len);
            {drem_y_reg, dq_y_reg} <= div_step(drem_y_reg, dq_y_reg, len);
        end

        if (cmd.mul_x)
            mprod_reg <= d6_reg * nx;
        if (cmd.mul_y)
        begin
            ux_reg    <= UW'(px_reg) + UW'(mprod_reg >>> NF) + UW'(3);
            mprod_reg <= d6_reg * ny;
        end
        if (cmd.sum_y)
            uy_reg <= UW'(py_reg) + UW'(mprod_reg >>> NF) + UW'(3);

        if (cmd.d3_init)
        begin
            v_x_reg <= VPW'(ux_reg >>> 1) + D3_BIAS;
            v_y_reg <= VPW'(uy_reg >>> 1) + D3_BIAS;
            r_x_reg <= '0;
            r_y_reg <= '0;
        end
        if (cmd.d3_step)
        begin
            v_x_reg <= v_x_reg << 4;
            v_y_reg <= v_y_reg << 4;
            r_x_reg <= d3_x[5:4];
            r_y_reg <= d3_y[5:4];
            q_x_reg <= {q_x_reg[VPW-5:0], d3_x[3:0]};
            q_y_reg <= {q_y_reg[VPW-5:0], d3_y[3:0]};
        end

        if (cmd.store_held)
        begin
            held_x_reg <= sat_x;
            held_y_reg <= sat_y;
            held_z_reg <= zero_reg;
        end

        if (cmd.load_held)
        begin
            curve_x_reg      <= held_x_reg;
            curve_y_reg      <= held_y_reg;
            zero_tangent_reg <= held_z_reg;
            run_last_reg     <= 1'b0;
            path_last_reg    <= 1'b0;
        end
        else if (cmd.load_new)
        begin
            curve_x_reg      <= sat_x;
            curve_y_reg      <= sat_y;
            zero_tangent_reg <= zero_reg;
            run_last_reg     <= 1'b1;
            path_last_reg    <= cmd.path_last;
        end
    end

    assign curve_x      = curve_x_reg;
    assign curve_y      = curve_y_reg;
    assign zero_tangent = zero_tangent_reg;
    assign run_last     = run_last_reg;
    assign path_last    = path_last_reg;

endmodule

@@ sv/bspline_offset_curve_points.sv @@
// Offset curve of a uniform cubic B-spline, one control point per request.
// Input channel in_valid/in_ready carries point_x, point_y and path_end;
// output channel out_valid/out_ready carries curve_x, curve_y, zero_tangent,
// run_last and path_last. cfg_wr_en/cfg_wr_data write offset_distance;
// write it only while the block is idle.
// The first two points of a path only fill the window. The third point's
// result is held and leaves just ahead of the fourth point's result; a path
// ending before its fourth point emits nothing.
// One point is worked at a time. A point that yields a result passes from
// acceptance to the output register through normalizing shifts and a check,
// squaring, a bit-serial square root, the two parallel restoring dividers for
// the unit normal, multiply and add, the divide-by-three digit loop, and
// finish and load; the held result, when present, leaves first. A zero tangent
// skips the normalizing shifts, squaring, root and division; points that only
// fill the window go straight back to idle.
// The output register frees the input side: a new point is taken while a
// result waits; if the receiver stalls, the second result of a point waits.
// Reset empties the window, drops any held result and zeroes offset_distance.
module bspline_offset_curve_points #(
    parameter int COORD_WIDTH = bsoc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic signed [COORD_WIDTH-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic                          path_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] curve_x,
    output logic signed [COORD_WIDTH-1:0] curve_y,
    output logic                          zero_tangent,
    output logic                          run_last,
    output logic                          path_last
);

    bsoc_pkg::cmd_t    cmd;
    bsoc_pkg::status_t status;

    bsoc_ctrl #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .path_end  (path_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bsoc_dpath #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .point_x      (point_x),
        .point_y      (point_y),
        .path_end     (path_end),
        .cmd          (cmd),
        .status       (status),
        .curve_x      (curve_x),
        .curve_y      (curve_y),
        .zero_tangent (zero_tangent),
        .run_last     (run_last),
        .path_last    (path_last)
    );

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = bsoc_pkg::COORD_WIDTH_DEF;
    localparam int NF = bsoc_pkg::NORM_FRAC;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } ctrl_point_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 zero;
        logic                 rlast;
        logic                 plast;
    } curve_point_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic signed [CW-1:0] cfg_wr_data;
    logic in_valid;
    logic in_ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic path_end;
    logic out_valid;
    logic out_ready;
    logic signed [CW-1:0] curve_x;
    logic signed [CW-1:0] curve_y;
    logic zero_tangent;
    logic run_last;
    logic path_last;

    bspline_offset_curve_points i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .path_end    (path_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .zero_tangent(zero_tangent),
        .run_last    (run_last),
        .path_last   (path_last)
    );

    ctrl_point_t  pending_points[$];
    curve_point_t expected_curve[$];

    // predictor state
    logic signed [CW-1:0] offset_dist;
    logic signed [CW-1:0] win_old_x, win_old_y, win_new_x, win_new_y;
    int unsigned          win_count;
    curve_point_t         held_point;
    logic                 held_valid;

    int errors;
    int points_sent;
    int curves_seen;
    int zero_seen;
    int paths_done;
    int idle_cycles;

    // generator state
    logic signed [CW-1:0] gen_prev1_x, gen_prev1_y, gen_prev2_x, gen_prev2_y;
    int                   gen_len;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [CW-1:0] round_sat(longint num);
        longint den;
        longint q;
        longint hi;
        longint lo;
        den = longint'(3) <<< (NF + 1);
        if (num >= 0)
            q = num / den;
        else
            q = -((-num + den - 1) / den);
        hi = longint'(C_MAX);
        lo = longint'(C_MIN);
        if (q > hi)
            q = hi;
        if (q < lo)
            q = lo;
        return q[CW-1:0];
    endfunction

    function automatic curve_point_t offset_knot(logic signed [CW-1:0] ax,
                                                 logic signed [CW-1:0] ay,
                                                 logic signed [CW-1:0] bx,
                                                 logic signed [CW-1:0] by,
                                                 logic signed [CW-1:0] cx,
                                                 logic signed [CW-1:0] cy);
        curve_point_t r;
        longint px, py, dx, dy, nx, ny;
        longint unsigned sx, sy, m, len, qx, qy;
        px = longint'(ax) + 4 * longint'(bx) + longint'(cx);
        py = longint'(ay) + 4 * longint'(by) + longint'(cy);
        dx = longint'(cx) - longint'(ax);
        dy = longint'(cy) - longint'(ay);
        nx = 0;
        ny = 0;
        r.zero = (dx == 0 && dy == 0);
        if (!r.zero)
        begin
            sx = (dx < 0) ? -dx : dx;
            sy = (dy < 0) ? -dy : dy;
            m = (sx > sy) ? sx : sy;
            while (m >= (64'd1 << 31))
            begin
                sx = sx >> 1;
                sy = sy >> 1;
                m = m >> 1;
            end
            while (m < (64'd1 << 30))
            begin
                sx = sx << 1;
                sy = sy << 1;
                m = m << 1;
            end
            len = int_sqrt(sx * sx + sy * sy);
            qx = ((sx << NF) + len / 2) / len;
            qy = ((sy << NF) + len / 2) / len;
            nx = (dy < 0) ? longint'(qy) : -longint'(qy);
            ny = (dx < 0) ? -longint'(qx) : longint'(qx);
        end
        r.x = round_sat((px <<< NF) + 6 * longint'(offset_dist) * nx + (longint'(3) <<< NF));
        r.y = round_sat((py <<< NF) + 6 * longint'(offset_dist) * ny + (longint'(3) <<< NF));
        r.rlast = 1'b1;
        r.plast = 1'b0;
        return r;
    endfunction

    task automatic predict_point(ctrl_point_t p);
        curve_point_t r;
        if (win_count >= 2)
        begin
            r = offset_knot(win_old_x, win_old_y, win_new_x, win_new_y, p.x, p.y);
            if (win_count == 2)
            begin
                held_point = r;
                held_point.rlast = 1'b0;
                held_valid = 1'b1;
            end
            else
            begin
                if (held_valid)
                begin
                    expected_curve.push_back(held_point);
                    held_valid = 1'b0;
                end
                r.plast = p.last;
                expected_curve.push_back(r);
            end
        end
        win_old_x = win_new_x;
        win_old_y = win_new_y;
        win_new_x = p.x;
        win_new_y = p.y;
        if (win_count < 3)
            win_count++;
        if (p.last)
        begin
            win_old_x = '0;
            win_old_y = '0;
            win_new_x = '0;
            win_new_y = '0;
            win_count = 0;
            held_valid = 1'b0;
            paths_done++;
        end
    endtask

    // driver: bursts and gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        ctrl_point_t p;
        logic        nxt_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            point_x <= '0;
            point_y <= '0;
            path_end <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            nxt_valid = in_valid;
            if (in_valid && in_ready)
            begin
                p.x = point_x;
                p.y = point_y;
                p.last = path_end;
                predict_point(p);
                points_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_points.size() != 0)
                begin
                    p = pending_points.pop_front();
                    point_x <= p.x;
                    point_y <= p.y;
                    path_end <= p.last;
                    nxt_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // monitor with its own stall pattern
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        curve_point_t e;
        int mode;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                curves_seen++;
                if (zero_tangent)
                    zero_seen++;
                if (expected_curve.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result x=%0d y=%0d", $time, curve_x, curve_y);
                end
                else
                begin
                    e = expected_curve.pop_front();
                    if (curve_x !== e.x || curve_y !== e.y || zero_tangent !== e.zero
                        || run_last !== e.rlast || path_last !== e.plast)
                    begin
                        errors++;
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0b rl=%0b pl=%0b",
                                 $time, e.x, e.y, e.zero, e.rlast, e.plast);
                        $display("%0t:          actual x=%0d y=%0d z=%0b rl=%0b pl=%0b",
                                 $time, curve_x, curve_y, zero_tangent, run_last, path_last);
                    end
                end
            end
            stall_phase++;
            mode = (stall_phase / 300) % 4;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 15) == 0);
                default: out_ready <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d results outstanding", $time,
                         expected_curve.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic queue_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic last);
        ctrl_point_t p;
        p.x = x;
        p.y = y;
        p.last = last;
        pending_points.push_back(p);
    endtask

    task automatic drain_and_settle();
        while (pending_points.size() != 0 || in_valid || expected_curve.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_offset(logic signed [CW-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        offset_dist = v;
    endtask

    function automatic logic signed [CW-1:0] random_coord(int sel, logic signed [CW-1:0] prev);
        case (sel)
            0: return CW'($urandom);
            1: return prev + CW'($signed($urandom_range(0, 8191)) - 4096);
            2: return ($urandom_range(0, 1) == 1) ? C_MAX : C_MIN;
            default: return CW'($signed($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    task automatic queue_random_path();
        int len;
        int sel;
        logic signed [CW-1:0] x, y;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
        sel = $urandom_range(0, 3);
        gen_prev1_x = CW'($urandom);
        gen_prev1_y = CW'($urandom);
        gen_prev2_x = gen_prev1_x;
        gen_prev2_y = gen_prev1_y;
        for (int i = 0; i < len; i++)
        begin
            if (i >= 2 && $urandom_range(0, 9) == 0)
            begin
                x = gen_prev2_x;
                y = gen_prev2_y;
            end
            else
            begin
                x = random_coord(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : sel,
                                 gen_prev1_x);
                y = random_coord(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : sel,
                                 gen_prev1_y);
            end
            queue_point(x, y, i == len - 1);
            gen_prev2_x = gen_prev1_x;
            gen_prev2_y = gen_prev1_y;
            gen_prev1_x = x;
            gen_prev1_y = y;
        end
        gen_len += len;
    endtask

    initial
    begin
        logic signed [CW-1:0] offsets[5];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        errors = 0;
        points_sent = 0;
        curves_seen = 0;
        zero_seen = 0;
        paths_done = 0;
        idle_cycles = 0;
        gen_len = 0;
        offset_dist = '0;
        win_old_x = '0;
        win_old_y = '0;
        win_new_x = '0;
        win_new_y = '0;
        win_count = 0;
        held_valid = 1'b0;
        held_point = '{default: '0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset offset of zero: short paths, zero tangent, an axis tangent
        queue_point(24'sd100, 24'sd100, 1'b1);
        queue_point(24'sd100, 24'sd100, 1'b0);
        queue_point(24'sd300, 24'sd200, 1'b1);
        queue_point(24'sd0, 24'sd0, 1'b0);
        queue_point(24'sd256, 24'sd0, 1'b0);
        queue_point(24'sd512, 24'sd0, 1'b1);
        queue_point(24'sd0, 24'sd0, 1'b0);
        queue_point(24'sd256, 24'sd256, 1'b0);
        queue_point(24'sd0, 24'sd0, 1'b0);
        queue_point(24'sd0, 24'sd512, 1'b0);
        queue_point(24'sd700, 24'sd512, 1'b1);
        drain_and_settle();

        // directed, extreme offsets and extreme coordinates
        set_offset(C_MAX);
        queue_point(C_MAX, C_MAX, 1'b0);
        queue_point(C_MAX, C_MIN, 1'b0);
        queue_point(C_MIN, C_MIN, 1'b0);
        queue_point(C_MIN, C_MAX, 1'b0);
        queue_point(C_MAX, C_MAX, 1'b1);
        drain_and_settle();
        set_offset(C_MIN);
        queue_point(C_MIN, 24'sd0, 1'b0);
        queue_point(24'sd0, C_MAX, 1'b0);
        queue_point(C_MAX, 24'sd0, 1'b0);
        queue_point(24'sd1, 24'sd1, 1'b0);
        queue_point(24'sd1, 24'sd1, 1'b0);
        queue_point(C_MAX, 24'sd0, 1'b1);
        drain_and_settle();

        offsets[0] = 24'sd0;
        offsets[1] = C_MAX;
        offsets[2] = C_MIN;
        offsets[3] = 24'sd1280;
        offsets[4] = -24'sd640;
        for (int ph = 0; ph < 7; ph++)
        begin
            set_offset((ph < 5) ? offsets[ph] : CW'($urandom));
            while (gen_len < (ph + 1) * 100)
                queue_random_path();
            drain_and_settle();
        end

        $display("Sent %0d control points in %0d paths over 10 offset settings;", points_sent,
                 paths_done);
        $display("checked %0d curve points, %0d with zero tangent.", curves_seen, zero_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
